### sv/mexp_pkg.sv
// Package for the modular exponentiation block.
// Operand widths and sequencer state codes; no dependencies.
package mexp_pkg;

	localparam int MOD_BITS = 31;
	localparam int EXP_BITS = 63;
	localparam int CNT_BITS = $clog2(MOD_BITS);

	typedef logic [MOD_BITS-1:0] mod_word_t;
	typedef logic [EXP_BITS-1:0] exp_word_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_REDUCE = 5'b00010,
		S_BIT    = 5'b00100,
		S_MUL    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

endpackage

### sv/mexp_modadd.sv
// Shared modular adder: (x + y + cin) mod m for x, y below m.
// Depends on mexp_pkg.
module mexp_modadd
	import mexp_pkg::*;
(
	input  mod_word_t x,
	input  mod_word_t y,
	input  logic      cin,
	input  mod_word_t m,
	output mod_word_t sum
);

	logic [MOD_BITS:0] raw;
	logic [MOD_BITS:0] red;

	always_comb begin
		raw = {1'b0, x} + {1'b0, y} + {{MOD_BITS{1'b0}}, cin};
		red = raw - {1'b0, m};
		sum = (raw >= {1'b0, m}) ? red[MOD_BITS-1:0] : raw[MOD_BITS-1:0];
	end

endmodule

### sv/modular_exponentiation.sv
// Top level of the modular exponentiation block.
// Depends on mexp_pkg and mexp_modadd.
//
// Computes base^exponent mod modulus, right-to-left binary method. One modular
// adder does all the arithmetic, one add or doubling per cycle: the base is first
// reduced one bit at a time, then each exponent bit takes a setup step and up to
// two shift-and-add products. Exponent zero or modulus below two skips the
// reduction and goes straight to the result strobe.
// busy is high from the cycle after start until the result strobe; done is
// high for one cycle with power_result and cannot be held off.
module modular_exponentiation
	import mexp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  mod_word_t base,
	input  exp_word_t exponent,
	input  mod_word_t modulus,
	output logic      done,
	output mod_word_t power_result
);

	state_t              state_q;
	mod_word_t           m_q;
	exp_word_t           e_q;
	mod_word_t           base_q;
	mod_word_t           r_q;
	mod_word_t           sq_q;
	mod_word_t           acc_q;
	mod_word_t           x_q;
	mod_word_t           y_q;
	logic                sel_sq_q;
	logic [CNT_BITS-1:0] cnt_q;
	mod_word_t           res_q;

	mod_word_t ua_x;
	mod_word_t ua_y;
	logic      ua_cin;
	mod_word_t ua_sum;

	mexp_modadd u_modadd (
		.x   (ua_x),
		.y   (ua_y),
		.cin (ua_cin),
		.m   (m_q),
		.sum (ua_sum)
	);

	always_comb begin
		ua_x   = x_q;
		ua_y   = x_q;
		ua_cin = 1'b0;
		if (state_q == S_REDUCE) begin
			ua_x   = acc_q;
			ua_y   = acc_q;
			ua_cin = base_q[MOD_BITS-1];
		end else if (y_q[0]) begin
			ua_x = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_q      <= '0;
			e_q      <= '0;
			base_q   <= '0;
			r_q      <= '0;
			sq_q     <= '0;
			acc_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			sel_sq_q <= 1'b0;
			cnt_q    <= '0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						m_q    <= modulus;
						e_q    <= exponent;
						base_q <= base;
						acc_q  <= '0;
						cnt_q  <= CNT_BITS'(MOD_BITS - 1);
						if (exponent == '0) begin
							res_q   <= mod_word_t'(1);
							state_q <= S_DONE;
						end else if (modulus <= mod_word_t'(1)) begin
							res_q   <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					acc_q  <= ua_sum;
					base_q <= base_q << 1;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						sq_q    <= ua_sum;
						r_q     <= mod_word_t'(1);
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					acc_q   <= '0;
					state_q <= S_MUL;
					if (e_q[0]) begin
						x_q      <= r_q;
						y_q      <= sq_q;
						sel_sq_q <= 1'b0;
					end else begin
						x_q      <= sq_q;
						y_q      <= sq_q;
						sel_sq_q <= 1'b1;
					end
				end
				S_MUL: begin
					if (y_q == '0) begin
						if (!sel_sq_q) begin
							r_q <= acc_q;
							if ((e_q >> 1) == '0) begin
								res_q   <= acc_q;
								state_q <= S_DONE;
							end else begin
								x_q      <= sq_q;
								y_q      <= sq_q;
								acc_q    <= '0;
								sel_sq_q <= 1'b1;
							end
						end else begin
							sq_q    <= acc_q;
							e_q     <= e_q >> 1;
							state_q <= S_BIT;
						end
					end else if (y_q[0]) begin
						acc_q  <= ua_sum;
						y_q[0] <= 1'b0;
					end else begin
						x_q <= ua_sum;
						y_q <= y_q >> 1;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = (state_q == S_DONE);
	assign power_result = res_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block not idle after result");

	a_mul_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (x_q < m_q && acc_q < m_q))
		else $error("product operand not reduced");

	a_reduce_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REDUCE) |-> (acc_q < m_q))
		else $error("base remainder not reduced");

endmodule
